// ===== rtl/lprw_pkg.sv =====
// Package with constants, codes and the result type of the linked page record walker.
package lprw_pkg;

  localparam int unsigned PAGE_BYTES         = 128;
  localparam int unsigned SLOTS_PER_PAGE     = 5;
  localparam int unsigned SECOND_LINE_OFFSET = 64;
  localparam int unsigned RECORD_LIMIT       = 65535;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned IDX_W      = 32 - PAGE_SHIFT;

  localparam logic [31:0] LINE_OFFSET  = 32'(SECOND_LINE_OFFSET);
  localparam logic [31:0] LINE_LIMIT   = 32'hFFFF_FFFF - LINE_OFFSET;
  localparam logic [2:0]  SLOT_FULL    = 3'(SLOTS_PER_PAGE);
  localparam logic [2:0]  SLOT_SECOND  = 3'd2;
  localparam logic [15:0] TOTAL_LIMIT  = 16'(RECORD_LIMIT);

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 4'd3;

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 144;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_DONE     = 2'd2
  } status_e;

  typedef struct packed {
    logic        walk_complete;
    logic [31:0] not_ready_total;
    logic        not_ready_flag;
    logic [15:0] release_page_id;
    logic        release_valid;
    logic [31:0] discard_addr;
    logic        discard_valid;
    logic [2:0]  consume_slot;
    logic [31:0] consume_page;
    logic [15:0] consume_index;
    status_e     status;
  } result_t;

endpackage

// ===== rtl/lprw_page_check.sv =====
// Pool membership and page boundary check that yields the page id of an address.
module lprw_page_check import lprw_pkg::*; (
  input  logic [31:0] addr_i,
  input  logic [31:0] pool_base_i,
  input  logic [16:0] pool_pages_i,
  output logic        ok_o,
  output logic [15:0] id_o
);

  logic [31:0]      off;
  logic [IDX_W-1:0] idx;

  assign off  = addr_i - pool_base_i;
  assign idx  = off[31:PAGE_SHIFT];
  assign id_o = idx[15:0];

  assign ok_o = (addr_i >= pool_base_i) &&
                (off[PAGE_SHIFT-1:0] == '0) &&
                (idx < IDX_W'(pool_pages_i)) &&
                (idx[IDX_W-1:16] == '0);

endmodule

// ===== rtl/lprw_core.sv =====
// Configuration registers, walk state and the per-record step logic.
module lprw_core import lprw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 step_i,
  input  logic                 page_ready_i,
  input  logic [31:0]          next_link_i,
  output result_t              result_o
);

  logic [31:0] first_q, base_q;
  logic [16:0] pages_q;
  logic [15:0] total_q;
  logic [31:0] cur_q, cur_d;
  logic [15:0] cnt_q, cnt_d;
  logic [2:0]  slot_q, slot_d;
  logic [31:0] nr_q, nr_d;

  logic        cur_ok, next_ok;
  logic [15:0] cur_id, next_id;
  logic [31:0] next_addr;
  logic [2:0]  slot_inc;
  logic        page_full;

  assign slot_inc  = slot_q + 3'd1;
  assign page_full = slot_inc >= SLOT_FULL;
  assign next_addr = page_full ? next_link_i : 32'd0;

  lprw_page_check u_cur_check (
    .addr_i       (cur_q),
    .pool_base_i  (base_q),
    .pool_pages_i (pages_q),
    .ok_o         (cur_ok),
    .id_o         (cur_id)
  );

  lprw_page_check u_next_check (
    .addr_i       (next_addr),
    .pool_base_i  (base_q),
    .pool_pages_i (pages_q),
    .ok_o         (next_ok),
    .id_o         (next_id)
  );

  always_comb begin
    result_o = '0;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    slot_d   = slot_q;
    nr_d     = nr_q;
    if (cnt_q >= total_q) begin
      result_o.status        = ST_DONE;
      result_o.walk_complete = 1'b1;
    end else if (!cur_ok || ((slot_q == SLOT_SECOND) && (cur_q > LINE_LIMIT))) begin
      result_o.status = ST_BAD_ADDR;
    end else begin
      if (slot_q == 3'd0) begin
        if (!page_ready_i) begin
          result_o.not_ready_flag = 1'b1;
          nr_d = nr_q + 32'd1;
        end
        result_o.discard_valid = 1'b1;
        result_o.discard_addr  = cur_q;
      end else if (slot_q == SLOT_SECOND) begin
        result_o.discard_valid = 1'b1;
        result_o.discard_addr  = cur_q + LINE_OFFSET;
      end
      result_o.consume_index = cnt_q;
      result_o.consume_page  = cur_q;
      result_o.consume_slot  = slot_q;
      cnt_d  = cnt_q + 16'd1;
      slot_d = slot_inc;
      if (page_full || (cnt_d == total_q)) begin
        slot_d                   = 3'd0;
        result_o.release_valid   = 1'b1;
        result_o.release_page_id = cur_id;
        cur_d                    = next_addr;
        if ((cnt_d != total_q) && !next_ok) begin
          result_o.status = ST_BAD_ADDR;
        end
      end
      result_o.walk_complete = (cnt_d == total_q);
    end
    result_o.not_ready_total = nr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      base_q  <= '0;
      pages_q <= 17'd1;
      total_q <= '0;
      cur_q   <= '0;
      cnt_q   <= '0;
      slot_q  <= '0;
      nr_q    <= '0;
    end else if (cfg_we_i && (cfg_index_i <= REG_TOTAL)) begin
      case (cfg_index_i)
        REG_FIRST_PAGE: first_q <= cfg_wdata_i;
        REG_POOL_BASE:  base_q  <= cfg_wdata_i;
        REG_POOL_PAGES: pages_q <= cfg_wdata_i[16:0];
        REG_TOTAL: begin
          total_q <= (cfg_wdata_i[15:0] > TOTAL_LIMIT) ? TOTAL_LIMIT : cfg_wdata_i[15:0];
        end
        default: ;
      endcase
      cur_q  <= (cfg_index_i == REG_FIRST_PAGE) ? cfg_wdata_i : first_q;
      cnt_q  <= '0;
      slot_q <= '0;
    end else if (step_i) begin
      cur_q  <= cur_d;
      cnt_q  <= cnt_d;
      slot_q <= slot_d;
      nr_q   <= nr_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SLOT_FULL)
    else $error("slot index left the page");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_we_i && (result_o.status == ST_DONE) |=>
      $stable(cnt_q) && $stable(slot_q) && $stable(cur_q))
    else $error("completed walk changed state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_we_i && result_o.release_valid |=> slot_q == 3'd0)
    else $error("release did not rewind the slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_ok |-> (17'(next_id) < pages_q))
    else $error("next page id outside the pool");

endmodule

// ===== rtl/linked_page_record_walker_top.sv =====
// Top level of the linked page record walker with stream ports and result register.
//
//  Channel      Direction  Handshake                       Content
//  s_axis       in         s_axis_tvalid/s_axis_tready     one record request
//  m_axis       out        m_axis_tvalid/m_axis_tready     one result per request
//  cfg          in         cfg_we_i, no wait               register write, restarts walk
//
// Each request is handled by the combinational step logic: it reads the walk state and
// the request, and the state and the result register are loaded at the same edge.
// A new request is taken every cycle while the result register is empty or is
// being drained, so one request per cycle is sustained with a ready sink.
// Reset clears the walk state and loads the register reset values; no sweep.
// A stalled result holds in the output register and stalls the input side.
module linked_page_record_walker_top import lprw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // page_ready [0], next_link [32:1], zero fill [39:33]
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status [1:0], consume_index [17:2], consume_page [49:18], consume_slot [52:50],
  // discard_valid [53], discard_addr [85:54], release_valid [86],
  // release_page_id [102:87], not_ready_flag [103], not_ready_total [135:104],
  // walk_complete [136], zero fill [143:137]
  output logic [OUT_W-1:0]     m_axis_tdata
);

  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    step;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  lprw_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (step),
    .page_ready_i (s_axis_tdata[0]),
    .next_link_i  (s_axis_tdata[32:1]),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_W - $bits(result_t))'(0), out_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("accepted request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == ST_DONE) |->
      out_q.walk_complete && !out_q.release_valid && !out_q.discard_valid)
    else $error("completed walk result carries a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.discard_valid |->
      (out_q.consume_slot == 3'd0) || (out_q.consume_slot == SLOT_SECOND))
    else $error("discard requested at a wrong slot");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the linked page record walker: directed chains, then random walks.
`timescale 1ns / 100ps

module tb_top;
  import lprw_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned RANDOM_RECORDS = 850;

  class page_walk_tracker;
    logic [31:0] first_page;
    logic [31:0] base_addr;
    logic [16:0] page_count;
    logic [15:0] record_total;
    logic [31:0] cur_page;
    logic [15:0] records_done;
    logic [2:0]  slot;
    logic [31:0] not_ready_cnt;
    result_t     pending_results[$];
    int unsigned mismatches;

    function new();
      first_page    = '0;
      base_addr     = '0;
      page_count    = 17'd1;
      record_total  = '0;
      not_ready_cnt = '0;
      mismatches    = 0;
      rewind();
    endfunction

    function void rewind();
      cur_page     = first_page;
      records_done = '0;
      slot         = '0;
    endfunction

    function bit page_id_of(input logic [31:0] addr, output logic [15:0] id);
      logic [31:0] off;
      logic [31:0] idx;
      id = '0;
      if (addr < base_addr) return 1'b0;
      off = addr - base_addr;
      if (off % PAGE_BYTES != 0) return 1'b0;
      idx = off / PAGE_BYTES;
      if (idx >= page_count || idx >= 32'h1_0000) return 1'b0;
      id = idx[15:0];
      return 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_FIRST_PAGE: first_page = val;
        REG_POOL_BASE:  base_addr = val;
        REG_POOL_PAGES: page_count = val[16:0];
        REG_TOTAL:      record_total = (val[15:0] > TOTAL_LIMIT) ? TOTAL_LIMIT : val[15:0];
        default:        return;
      endcase
      rewind();
    endfunction

    // True while the next request would consume a record.
    function bit live();
      logic [15:0] id;
      return records_done < record_total && page_id_of(cur_page, id) &&
             !(slot == SLOT_SECOND && cur_page > LINE_LIMIT);
    endfunction

    function void take_request(logic ready, logic [31:0] link);
      result_t     r;
      logic [15:0] id;
      logic [15:0] new_id;
      r = '0;
      r.status = ST_OK;
      if (records_done >= record_total) begin
        r.status        = ST_DONE;
        r.walk_complete = 1'b1;
      end else if (!page_id_of(cur_page, id) ||
                   (slot == SLOT_SECOND && cur_page > LINE_LIMIT)) begin
        r.status = ST_BAD_ADDR;
      end else begin
        if (slot == '0) begin
          if (!ready) begin
            r.not_ready_flag = 1'b1;
            not_ready_cnt++;
          end
          r.discard_valid = 1'b1;
          r.discard_addr  = cur_page;
        end else if (slot == SLOT_SECOND) begin
          r.discard_valid = 1'b1;
          r.discard_addr  = cur_page + LINE_OFFSET;
        end
        r.consume_index = records_done;
        r.consume_page  = cur_page;
        r.consume_slot  = slot;
        records_done++;
        slot++;
        if (slot >= SLOT_FULL || records_done == record_total) begin
          r.release_valid   = 1'b1;
          r.release_page_id = id;
          cur_page = (slot >= SLOT_FULL) ? link : '0;
          slot     = '0;
          if (records_done != record_total && !page_id_of(cur_page, new_id)) begin
            r.status = ST_BAD_ADDR;
          end
        end
        r.walk_complete = (records_done == record_total);
      end
      r.not_ready_total = not_ready_cnt;
      pending_results.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        mismatches++;
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
      end
    endfunction

    function void match_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result with no request outstanding: status 0x%0h", got.status);
        return;
      end
      exp = pending_results.pop_front();
      compare("status", 32'(exp.status), 32'(got.status));
      compare("consume_index", 32'(exp.consume_index), 32'(got.consume_index));
      compare("consume_page", exp.consume_page, got.consume_page);
      compare("consume_slot", 32'(exp.consume_slot), 32'(got.consume_slot));
      compare("discard_valid", 32'(exp.discard_valid), 32'(got.discard_valid));
      compare("discard_addr", exp.discard_addr, got.discard_addr);
      compare("release_valid", 32'(exp.release_valid), 32'(got.release_valid));
      compare("release_page_id", 32'(exp.release_page_id), 32'(got.release_page_id));
      compare("not_ready_flag", 32'(exp.not_ready_flag), 32'(got.not_ready_flag));
      compare("not_ready_total", exp.not_ready_total, got.not_ready_total);
      compare("walk_complete", 32'(exp.walk_complete), 32'(got.walk_complete));
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [31:0]          cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;

  page_walk_tracker tracker = new();
  int unsigned      src_max   = 16;
  int unsigned      sink_max  = 16;
  int unsigned      sink_wait = 0;
  int unsigned      cycles    = 0;

  linked_page_record_walker_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.match_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
      sink_wait = $urandom_range(0, sink_max);
    end else if (sink_wait != 0) begin
      sink_wait--;
    end
    m_axis_tready <= (sink_wait == 0);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("linked_page_record_walker_top test failed");
      $finish;
    end
  end

  task automatic send(logic ready, logic [31:0] link);
    int unsigned gap;
    gap = $urandom_range(0, src_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-33){1'b0}}, link, ready};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_request(ready, link);
  endtask

  task automatic hold_off();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    tracker.write_reg(idx, val);
  endtask

  task automatic setup_walk(logic [31:0] first, logic [31:0] base, logic [31:0] pages,
                            logic [31:0] total);
    hold_off();
    cfg_write(REG_FIRST_PAGE, first);
    cfg_write(REG_POOL_BASE, base);
    cfg_write(REG_POOL_PAGES, pages);
    cfg_write(REG_TOTAL, total);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_walk(inout int unsigned consumed);
    logic [CFG_IDX_W-1:0] regs[4];
    logic [31:0]          vals[4];
    logic [31:0]          base;
    logic [31:0]          link;
    logic [16:0]          pages;
    int unsigned          span;
    int unsigned          start;
    int unsigned          n;
    int unsigned          i;
    regs = '{REG_FIRST_PAGE, REG_POOL_BASE, REG_POOL_PAGES, REG_TOTAL};
    src_max  = ($urandom_range(0, 2) == 0) ? 0 : 16;
    sink_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
    case ($urandom_range(0, 9))
      0:       base = '0;
      1:       base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
      2:       base = $urandom;
      default: base = $urandom_range(0, 32'hFFFF) * PAGE_BYTES;
    endcase
    case ($urandom_range(0, 9))
      0:       pages = '0;
      1:       pages = 17'h1_0000;
      2:       pages = 17'h1_FFFF;
      3:       pages = 17'($urandom);
      default: pages = 17'($urandom_range(1, 12));
    endcase
    span = (pages == 0) ? 1 : (pages > 17'h1_0000) ? 32'h1_0000 : pages;
    vals[0] = ($urandom_range(0, 9) == 0) ? $urandom :
              base + $urandom_range(0, span - 1) * PAGE_BYTES;
    vals[1] = base;
    vals[2] = ($urandom & 32'hFFFE_0000) | 32'(pages);
    case ($urandom_range(0, 19))
      0:       vals[3] = '0;
      1:       vals[3] = 32'(TOTAL_LIMIT);
      default: vals[3] = $urandom_range(1, 60);
    endcase
    vals[3] = ($urandom & 32'hFFFF_0000) | {16'h0, vals[3][15:0]};
    hold_off();
    start = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      cfg_write(regs[(start + k) % 4], vals[(start + k) % 4]);
    end
    if ($urandom_range(0, 4) == 0) begin
      cfg_write(CFG_IDX_W'($urandom_range(int'(REG_TOTAL) + 1, (1 << CFG_IDX_W) - 1)),
                $urandom);
    end
    cfg_we_i <= 1'b0;
    n = $urandom_range(15, 50);
    i = 0;
    while (i < n && tracker.live()) begin
      if ($urandom_range(0, 29) == 0) hold_off();
      case ($urandom_range(0, 19))
        0, 1:    link = $urandom;
        2:       link = '0;
        3:       link = base + $urandom_range(0, span - 1) * PAGE_BYTES + $urandom_range(1, 127);
        default: link = base + $urandom_range(0, span - 1) * PAGE_BYTES;
      endcase
      send($urandom_range(0, 3) != 0, link);
      consumed++;
      i++;
    end
    repeat ($urandom_range(1, 2)) send($urandom_range(0, 1), $urandom);
  endtask

  initial begin
    int unsigned consumed;
    consumed = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: no records to walk.
    send(1'b1, 32'hFFFF_FFFF);
    send(1'b0, 32'h0);

    // Highest page id, not-ready page, then a link whose id reaches the id bound.
    setup_walk(32'h007F_FF80, 32'h0, 32'h1_0000, 32'd7);
    send(1'b0, 32'h0);
    send(1'b1, 32'h0);
    send(1'b1, 32'hFFFF_FFFF);
    send(1'b1, 32'h0);
    send(1'b1, 32'h0080_0000);
    send(1'b1, 32'h0);

    // Oversized pool register and record total limit.
    setup_walk(32'h0080_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(1'b1, 32'h0);

    // Empty pool.
    setup_walk(32'h0, 32'h0, 32'h0, 32'd3);
    send(1'b1, 32'h0);

    // Second cache line past the top of the address space.
    setup_walk(32'hFFFF_FFC0, 32'hFFFF_FFC0, 32'd1, 32'd9);
    send(1'b0, 32'h0);
    send(1'b1, 32'h0);
    send(1'b1, 32'h0);
    send(1'b1, 32'h0);

    // Misaligned first page, then a first page below the pool.
    setup_walk(32'h0000_1040, 32'h0000_1000, 32'd4, 32'd5);
    send(1'b1, 32'h0);
    hold_off();
    cfg_write(REG_FIRST_PAGE, 32'h0000_0FFF);
    cfg_we_i <= 1'b0;
    send(1'b1, 32'h0);

    // Writes to unused indexes do not restart; the walk ends mid-page.
    setup_walk(32'h0000_1080, 32'h0000_1000, 32'd4, 32'd7);
    send(1'b1, 32'h0);
    send(1'b1, 32'h0);
    hold_off();
    cfg_write(CFG_IDX_W'($urandom_range(int'(REG_TOTAL) + 1, (1 << CFG_IDX_W) - 1)), $urandom);
    cfg_write('1, $urandom);
    cfg_we_i <= 1'b0;
    send(1'b1, 32'h0);
    send(1'b1, 32'h0);
    send(1'b1, 32'h0000_1000);
    send(1'b0, 32'h0);
    send(1'b1, 32'hFFFF_FFFF);
    send(1'b1, 32'h0);

    while (consumed < RANDOM_RECORDS) random_walk(consumed);

    hold_off();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("linked_page_record_walker_top test passed");
    end else begin
      $display("linked_page_record_walker_top test failed");
    end
    $finish;
  end

endmodule
